// File: hw/rtl/htilr_pkg.sv
`timescale 1ns / 1ps
// Package: table geometry, field widths, operation and status codes, row types.
package htilr_pkg;

  localparam int NUM_BUCKETS  = 64;   // power of two: bucket index is a mask of the key
  localparam int BUCKET_SLOTS = 4;

  localparam int KEY_W  = 31;
  localparam int VAL_W  = 32;
  localparam int OP_W   = 2;
  localparam int STAT_W = 2;

  localparam int BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int SLOT_W = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } slot_t;

  typedef slot_t [BUCKET_SLOTS-1:0] row_t;

  localparam int ROW_W = $bits(row_t);

endpackage

// File: hw/rtl/htilr_req_if.sv
`timescale 1ns / 1ps
// Request channel: valid/ready handshake carrying operation, key and value.
interface htilr_req_if import htilr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  req_type;
  logic [KEY_W-1:0] req_key;
  logic [VAL_W-1:0] req_value;

  modport source (output valid, output req_type, output req_key, output req_value,
                  input ready);
  modport sink   (input valid, input req_type, input req_key, input req_value,
                  output ready);
endinterface

// File: hw/rtl/htilr_rsp_if.sv
`timescale 1ns / 1ps
// Response channel: valid/ready handshake carrying status and read value.
interface htilr_rsp_if import htilr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [VAL_W-1:0]  read_value;

  modport source (output valid, output status, output read_value, input ready);
  modport sink   (input valid, input status, input read_value, output ready);
endinterface

// File: hw/rtl/htilr_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module htilr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                       clk_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/hash_table_insert_lookup_remove.sv
`timescale 1ns / 1ps
// Top level: bucketed key-value table with insert, lookup and remove.
//
// Usage:
//   req_i  - request transfers: req_type (insert, lookup, remove), req_key, req_value.
//   rsp_o  - one response transfer per request, in order: status and read_value.
//   Bucket = req_key mod NUM_BUCKETS; each bucket holds BUCKET_SLOTS slots.
//   The slots of one bucket (key and value) form one row of a bucket RAM;
//   the slot valid bits sit in flops so that reset empties the table at once.
// Sequence:
//   Request transfer (S_IDLE): the bucket row is read from the RAM.
//   S_EXEC: all slots compared in parallel, row written back on insert,
//            slot valid bits updated on insert or remove, response
//            registered in the output register and shown on rsp_o.
//   A new request is taken only in S_IDLE: the read/write-back of the bucket
//   row holds one request at a time, so back-to-back requests to the same
//   bucket need no forwarding.
// Reset: all slots empty, no response pending; usable in the first cycle.
// Stall: a response waits in the output register; the next request is still
//   taken, and its compare cycle holds until the output register is free.
module hash_table_insert_lookup_remove import htilr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  htilr_req_if.sink    req_i,
  htilr_rsp_if.source  rsp_o
);

  // ---------------------------------------------------------------- control
  state_e state_q, state_d;

  logic req_xfer;   // request transfer this cycle
  logic rsp_xfer;   // response transfer this cycle
  logic exec_go;    // compare/write-back cycle completes
  logic in_ready;

  logic out_valid_q, out_valid_d;

  assign req_xfer = req_i.valid && in_ready;
  assign rsp_xfer = out_valid_q && rsp_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_xfer) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (exec_go) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready = 1'b0;
    exec_go  = 1'b0;
    case (state_q)
      S_IDLE: in_ready = 1'b1;
      S_EXEC: exec_go  = !out_valid_q || rsp_o.ready;
      default: begin
        in_ready = 1'b0;
        exec_go  = 1'b0;
      end
    endcase
  end

  // ------------------------------------------------------- request capture
  logic [OP_W-1:0]  op_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] val_q;
  logic [BKT_W-1:0] bkt_q;
  logic [BKT_W-1:0] req_bkt;

  assign req_bkt = BKT_W'(req_i.req_key % NUM_BUCKETS);

  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      op_q  <= req_i.req_type;
      key_q <= req_i.req_key;
      val_q <= req_i.req_value;
      bkt_q <= req_bkt;
    end
  end

  // -------------------------------------------------------------- bucket RAM
  row_t rd_row;
  row_t wr_row;
  logic ram_we;

  htilr_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_BUCKETS)
  ) u_bucket_ram (
    .clk_i   (clk_i),
    .re_i    (req_xfer),
    .raddr_i (req_bkt),
    .rdata_o (rd_row),
    .we_i    (ram_we),
    .waddr_i (bkt_q),
    .wdata_i (wr_row)
  );

  // slot valid bits, one row per bucket
  logic [BUCKET_SLOTS-1:0] valid_q [NUM_BUCKETS];
  logic [BUCKET_SLOTS-1:0] row_valid;

  assign row_valid = valid_q[bkt_q];

  // ---------------------------------------------------------- slot compare
  logic [BUCKET_SLOTS-1:0] hit_vec;
  logic                    any_hit;
  logic                    any_free;
  logic [SLOT_W-1:0]       hit_idx;
  logic [SLOT_W-1:0]       free_idx;

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int s = 0; s < BUCKET_SLOTS; s++) begin
      hit_vec[s] = row_valid[s] && (rd_row[s].key == key_q);
    end
    // lowest-numbered slot wins
    for (int s = BUCKET_SLOTS - 1; s >= 0; s--) begin
      if (hit_vec[s])    hit_idx  = SLOT_W'(s);
      if (!row_valid[s]) free_idx = SLOT_W'(s);
    end
    any_hit  = |hit_vec;
    any_free = !(&row_valid);
  end

  // ------------------------------------------------------------ operation
  logic [STAT_W-1:0]       res_status;
  logic [VAL_W-1:0]        res_value;
  logic                    do_insert;
  logic                    do_remove;
  logic [BUCKET_SLOTS-1:0] row_valid_new;

  always_comb begin
    res_status    = ST_MISS;
    res_value     = '0;
    do_insert     = 1'b0;
    do_remove     = 1'b0;
    wr_row        = rd_row;
    row_valid_new = row_valid;
    case (op_q)
      OP_INSERT: begin
        if (any_hit) begin
          res_status = ST_MISS;
        end else if (any_free) begin
          res_status = ST_OK;
          do_insert  = 1'b1;
        end else begin
          res_status = ST_FULL;
        end
      end
      OP_LOOKUP: begin
        if (any_hit) begin
          res_status = ST_OK;
          res_value  = rd_row[hit_idx].value;
        end
      end
      OP_REMOVE: begin
        if (any_hit) begin
          res_status = ST_OK;
          do_remove  = 1'b1;
        end
      end
      default: res_status = ST_MISS;   // unknown operation: table untouched
    endcase
    if (do_insert) begin
      wr_row[free_idx].key   = key_q;
      wr_row[free_idx].value = val_q;
      row_valid_new[free_idx] = 1'b1;
    end
    if (do_remove) begin
      row_valid_new[hit_idx] = 1'b0;
    end
  end

  assign ram_we = exec_go && do_insert;

  // ------------------------------------------------------- output register
  logic [STAT_W-1:0] out_status_q;
  logic [VAL_W-1:0]  out_value_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (exec_go)       out_valid_d = 1'b1;
    else if (rsp_xfer) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (exec_go) begin
      out_status_q <= res_status;
      out_value_q  <= res_value;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.read_value = out_value_q;
  assign req_i.ready      = in_ready;

  // --------------------------------------------------------- control flops
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      for (int b = 0; b < NUM_BUCKETS; b++) begin
        valid_q[b] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (exec_go && (do_insert || do_remove)) begin
        valid_q[bkt_q] <= row_valid_new;
      end
    end
  end

`ifndef SYNTHESIS
  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_xfer |=> (state_q == S_EXEC))
    else $error("request transfer not followed by compare cycle");

  a_exec_sets_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_go |=> out_valid_q)
    else $error("completed request left no response");

  a_full_only_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_go && (res_status == ST_FULL)) |-> ((op_q == OP_INSERT) && (&row_valid)))
    else $error("bucket-full status without a full bucket on insert");

  a_value_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.read_value != '0)) |-> (rsp_o.status == ST_OK))
    else $error("nonzero read value on a failed request");

  a_no_req_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |-> !req_xfer && !ram_we || exec_go)
    else $error("request taken or row written outside its slot");
`endif

endmodule

// File: tb/tb_hash_table_insert_lookup_remove.sv
`timescale 1ns / 1ps
// Testbench: self-checking regression of the bucketed key-value table.
module tb_hash_table_insert_lookup_remove;
  import htilr_pkg::*;

  // Geometry and codes. The package has no name for the fourth opcode,
  // which the block must answer as a miss without touching the table.
  localparam int              TOTAL_SLOTS = NUM_BUCKETS * BUCKET_SLOTS;
  localparam logic [OP_W-1:0] OP_UNKNOWN  = 2'd3;
  localparam logic [KEY_W-1:0] KEY_MAX    = {KEY_W{1'b1}};
  localparam logic [VAL_W-1:0] VAL_MAX    = {VAL_W{1'b1}};
  // Largest multiplier k such that k*NUM_BUCKETS + bucket still fits in a key.
  localparam longint          HIGH_MAX    = (64'd1 << KEY_W) / NUM_BUCKETS - 1;
  localparam int              HOT_BUCKETS = 4;
  localparam int              HIGH_POOL   = 10;
  localparam int              LONG_HOLD   = 300;
  localparam int              CYCLE_LIMIT = 400000;

  // One response as the table should answer it.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  read_value;
  } answer_t;

  logic clk_i;
  logic rst_ni;

  htilr_req_if req_if ();
  htilr_rsp_if rsp_if ();

  hash_table_insert_lookup_remove uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Shadow copy of the table: one entry per slot, buckets laid out in order.
  bit               shadow_used [TOTAL_SLOTS];
  logic [KEY_W-1:0] shadow_key  [TOTAL_SLOTS];
  logic [VAL_W-1:0] shadow_val  [TOTAL_SLOTS];

  // Answers owed by the block, oldest first.
  answer_t answer_q[$];

  int err_count;
  int cycles;

  // Sender shaping: bursts of random length, idle gaps drawn up to gap_max.
  int burst_left;
  int gap_max;
  // Receiver shaping: percent of cycles with ready low, plus an optional
  // long hold-off that the receiver counts down on its own.
  int stall_pct;
  int hold_request;
  int hold_left;

  // Key pools for the random part: a few hot buckets and a handful of
  // multipliers, so keys collide, buckets fill and lookups hit.
  int unsigned hot_bucket [HOT_BUCKETS];
  int unsigned high_pool  [HIGH_POOL];

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Apply one request to the shadow table and return what the block must say.
  // A search takes the lowest matching slot; insert takes the lowest free slot,
  // and a present key is reported before a full bucket.
  function automatic answer_t table_apply(input logic [OP_W-1:0]  op,
                                          input logic [KEY_W-1:0] key,
                                          input logic [VAL_W-1:0] value);
    int      base;
    int      hit;
    int      free_idx;
    answer_t ans;
    base          = int'(key % NUM_BUCKETS) * BUCKET_SLOTS;
    hit           = -1;
    free_idx      = -1;
    ans.status     = ST_MISS;
    ans.read_value = '0;
    for (int s = BUCKET_SLOTS - 1; s >= 0; s--) begin
      if (shadow_used[base + s] && shadow_key[base + s] == key) hit = base + s;
      if (!shadow_used[base + s]) free_idx = base + s;
    end
    case (op)
      OP_INSERT: begin
        if (hit < 0) begin
          if (free_idx < 0) begin
            ans.status = ST_FULL;
          end else begin
            shadow_used[free_idx] = 1'b1;
            shadow_key[free_idx]  = key;
            shadow_val[free_idx]  = value;
            ans.status            = ST_OK;
          end
        end
      end
      OP_LOOKUP: begin
        if (hit >= 0) begin
          ans.status     = ST_OK;
          ans.read_value = shadow_val[hit];
        end
      end
      OP_REMOVE: begin
        if (hit >= 0) begin
          shadow_used[hit] = 1'b0;
          ans.status       = ST_OK;
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  // Offer one request and hold it until the transfer. Fields and valid change
  // at the falling edge only; the transfer is seen at the rising edge.
  task automatic send_req(input logic [OP_W-1:0]  op,
                          input logic [KEY_W-1:0] key,
                          input logic [VAL_W-1:0] value);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap        = $urandom_range(0, gap_max);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        req_if.valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    req_if.valid     = 1'b1;
    req_if.req_type  = op;
    req_if.req_key   = key;
    req_if.req_value = value;
    do @(posedge clk_i); while (!req_if.ready);
    answer_q.push_back(table_apply(op, key, value));
  endtask

  // Drop valid and wait for every owed answer, then let the block idle.
  task automatic wait_for_answers();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    burst_left   = 0;
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return VAL_MAX;
    return $urandom;
  endfunction

  // Mostly keys from the hot pool; some fully random keys for the miss path.
  function automatic logic [KEY_W-1:0] pick_key();
    longint k;
    if ($urandom_range(0, 99) < 88) begin
      k = longint'(high_pool[$urandom_range(0, HIGH_POOL - 1)]) * NUM_BUCKETS
          + hot_bucket[$urandom_range(0, HOT_BUCKETS - 1)];
      return k[KEY_W-1:0];
    end
    return KEY_W'($urandom);
  endfunction

  function automatic logic [OP_W-1:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return OP_INSERT;
    if (r < 70) return OP_LOOKUP;
    if (r < 95) return OP_REMOVE;
    return OP_UNKNOWN;
  endfunction

  // New hot buckets and multipliers; the multiplier extremes are always in,
  // so the top and bottom key bits both get exercised.
  task automatic reshuffle_pools();
    for (int i = 0; i < HOT_BUCKETS; i++) hot_bucket[i] = $urandom_range(0, NUM_BUCKETS - 1);
    high_pool[0] = 0;
    high_pool[1] = int'(HIGH_MAX);
    for (int i = 2; i < HIGH_POOL; i++) high_pool[i] = $urandom_range(0, int'(HIGH_MAX));
  endtask

  // Edges of the key and value ranges, every operation, a bucket filled to the
  // top, insert of a present key into a full bucket, reuse of a freed slot.
  task automatic test_directed();
    gap_max   = 2;
    stall_pct = 20;
    send_req(OP_LOOKUP,  '0,               $urandom);     // empty table: miss
    send_req(OP_REMOVE,  '0,               $urandom);     // nothing to remove
    send_req(OP_INSERT,  '0,               '0);
    send_req(OP_INSERT,  KEY_MAX,          VAL_MAX);      // last bucket
    send_req(OP_LOOKUP,  '0,               $urandom);
    send_req(OP_LOOKUP,  KEY_MAX,          $urandom);
    send_req(OP_INSERT,  '0,               32'h1234_5678); // already present
    send_req(OP_INSERT,  KEY_W'(KEY_MAX - NUM_BUCKETS),  32'hA5A5_A5A5);
    send_req(OP_INSERT,  KEY_W'(NUM_BUCKETS - 1),        32'h5A5A_5A5A);
    send_req(OP_INSERT,  KEY_W'(2 * NUM_BUCKETS - 1),    32'h0000_0001); // bucket now full
    send_req(OP_INSERT,  KEY_W'(3 * NUM_BUCKETS - 1),    32'hDEAD_BEEF); // no room
    send_req(OP_INSERT,  KEY_MAX,          '0);           // present beats full
    send_req(OP_LOOKUP,  KEY_W'(3 * NUM_BUCKETS - 1),    $urandom);
    send_req(OP_UNKNOWN, '0,               VAL_MAX);      // must not disturb key 0
    send_req(OP_LOOKUP,  '0,               $urandom);
    send_req(OP_REMOVE,  KEY_W'(NUM_BUCKETS - 1),        $urandom);
    send_req(OP_INSERT,  KEY_W'(3 * NUM_BUCKETS - 1),    32'h8000_0000); // freed slot
    send_req(OP_LOOKUP,  KEY_W'(3 * NUM_BUCKETS - 1),    $urandom);
    send_req(OP_REMOVE,  '0,               $urandom);
    send_req(OP_LOOKUP,  '0,               $urandom);
    send_req(OP_REMOVE,  '0,               $urandom);
    send_req(OP_UNKNOWN, KEY_MAX,          VAL_MAX);
    send_req(OP_LOOKUP,  KEY_MAX,          $urandom);
    wait_for_answers();
  endtask

  // Back-to-back requests into one bucket with no idling on either side:
  // each request must see the write-back of the one before it.
  task automatic test_same_bucket_stream();
    int unsigned bucket;
    bucket    = $urandom_range(0, NUM_BUCKETS - 1);
    gap_max   = 0;
    stall_pct = 0;
    for (int i = 0; i < 48; i++)
      send_req(pick_op(), KEY_W'($urandom_range(0, 6) * NUM_BUCKETS + bucket), pick_value());
    wait_for_answers();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering,
  // so the block fills and must hold its input.
  task automatic test_backpressure();
    reshuffle_pools();
    gap_max      = 0;
    stall_pct    = 0;
    hold_request = LONG_HOLD;
    for (int i = 0; i < 40; i++) send_req(pick_op(), pick_key(), pick_value());
    wait_for_answers();
  endtask

  // Bulk random traffic in phases; each phase has its own idling profile and
  // key pools, and ends with the sender waiting for every answer.
  task automatic test_random();
    int phase_gap  [5] = '{0, 4, 10, 2, 6};
    int phase_stall[5] = '{0, 30, 60, 10, 80};
    for (int p = 0; p < 5; p++) begin
      reshuffle_pools();
      gap_max   = phase_gap[p];
      stall_pct = phase_stall[p];
      for (int i = 0; i < 300; i++) send_req(pick_op(), pick_key(), pick_value());
      wait_for_answers();
    end
  endtask

  // Receiver: ready changes at the falling edge, either held low by a pending
  // hold-off or dropped at random at the current stall rate.
  always @(negedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      rsp_if.ready = 1'b0;
      hold_left--;
    end else begin
      rsp_if.ready = ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Response checker: every transfer is compared with the oldest owed answer.
  always @(posedge clk_i) begin : check_rsp
    answer_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (answer_q.size() == 0) begin
        $error("unexpected response: status %0d read_value 0x%08h",
               rsp_if.status, rsp_if.read_value);
        err_count++;
      end else begin
        want = answer_q.pop_front();
        if (rsp_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_if.status);
          err_count++;
        end
        if (rsp_if.read_value !== want.read_value) begin
          $error("read_value: expected 0x%08h, got 0x%08h",
                 want.read_value, rsp_if.read_value);
          err_count++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    err_count        = 0;
    cycles           = 0;
    burst_left       = 0;
    gap_max          = 0;
    stall_pct        = 0;
    hold_request     = 0;
    hold_left        = 0;
    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.req_type  = OP_INSERT;
    req_if.req_key   = '0;
    req_if.req_value = '0;
    rsp_if.ready     = 1'b0;
    for (int i = 0; i < TOTAL_SLOTS; i++) shadow_used[i] = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_same_bucket_stream();
    test_backpressure();
    test_random();

    // Any stray response after the last answer still gets flagged here.
    repeat (8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
